/* rtl/itoa_pkg.sv */
`default_nettype none

package itoa_pkg;

  // Radix selector kept while an item is converted
  typedef logic [1:0] radix_t;

  localparam radix_t RadixBin = 2'd0;
  localparam radix_t RadixOct = 2'd1;
  localparam radix_t RadixDec = 2'd2;
  localparam radix_t RadixHex = 2'd3;

  // Requested base codes on the input
  localparam logic [4:0] BaseBin = 5'd2;
  localparam logic [4:0] BaseOct = 5'd8;
  localparam logic [4:0] BaseDec = 5'd10;
  localparam logic [4:0] BaseHex = 5'd16;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharNul   = 8'h00;

  // Digit counts of a full 32-bit word per radix
  localparam logic [5:0] DigitsBin = 6'd32;
  localparam logic [5:0] DigitsOct = 6'd11;
  localparam logic [5:0] DigitsDec = 6'd10;
  localparam logic [5:0] DigitsHex = 6'd8;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'b0, d};
    end else begin
      c = CharA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/integer_to_ascii_digits.sv */
`default_nettype none

// Channel    Dir  Handshake                        Payload
// s_axis     in   s_axis_tvalid_i/s_axis_tready_o  tdata: value[31:0], base[36:32]
// m_axis     out  m_axis_tvalid_o/m_axis_tready_i  tdata: character; tlast; tuser: bad_base
//
// One number at a time: base 10 first runs a bit-serial double-dabble over all 32 value bits,
// then leading zero digits drop one per cycle and one character leaves per cycle.
// Base 10 puts a minus sign before a negative number; an unsupported base yields one error item.
// Output stalls hold the emit step; the next number is taken while the last item waits.
// Reset is asynchronous, active low, and clears control state only.
module integer_to_ascii_digits (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // [31:0] value, [36:32] base, [39:37] zero
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] character
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] bad_base
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;
  localparam logic [2:0] StErr  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [5:0]             cnt_q, cnt_d;
  itoa_pkg::radix_t       radix_q, radix_d;
  logic                   neg_q, neg_d;
  logic [39:0]            sh_q, sh_d;
  logic [31:0]            bin_q, bin_d;
  logic                   ov_q, ov_d;
  logic [7:0]             oc_q, oc_d;
  logic                   ol_q, ol_d;
  logic                   ob_q, ob_d;

  logic        in_acc;
  logic        can_load;
  logic [31:0] in_value;
  logic [4:0]  in_base;
  logic [31:0] mag;
  logic [3:0]  top_digit;
  logic [39:0] sh_next;
  logic [39:0] bcd_adj;

  assign in_value = s_axis_tdata_i[31:0];
  assign in_base  = s_axis_tdata_i[36:32];

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load        = !ov_q || m_axis_tready_i;

  assign mag = in_value[31] ? (~in_value + 32'd1) : in_value;

  always_comb begin
    case (radix_q)
      itoa_pkg::RadixBin: begin
        top_digit = {3'b0, sh_q[39]};
        sh_next   = {sh_q[38:0], 1'b0};
      end
      itoa_pkg::RadixOct: begin
        top_digit = {1'b0, sh_q[39:37]};
        sh_next   = {sh_q[36:0], 3'b0};
      end
      default: begin
        top_digit = sh_q[39:36];
        sh_next   = {sh_q[35:0], 4'b0};
      end
    endcase
  end

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i*4 +: 4] = (sh_q[i*4 +: 4] >= 4'd5) ? (sh_q[i*4 +: 4] + 4'd3)
                                                    : sh_q[i*4 +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    sh_d    = sh_q;
    bin_d   = bin_q;
    ov_d    = ov_q;
    oc_d    = oc_q;
    ol_d    = ol_q;
    ob_d    = ob_q;

    // Drop the item once taken; a load below overrides this
    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          neg_d = 1'b0;
          if (in_base == itoa_pkg::BaseBin) begin
            radix_d = itoa_pkg::RadixBin;
            sh_d    = {in_value, 8'b0};
            cnt_d   = itoa_pkg::DigitsBin;
            state_d = StSkip;
          end else if (in_base == itoa_pkg::BaseOct) begin
            radix_d = itoa_pkg::RadixOct;
            sh_d    = {1'b0, in_value, 7'b0};
            cnt_d   = itoa_pkg::DigitsOct;
            state_d = StSkip;
          end else if (in_base == itoa_pkg::BaseHex) begin
            radix_d = itoa_pkg::RadixHex;
            sh_d    = {in_value, 8'b0};
            cnt_d   = itoa_pkg::DigitsHex;
            state_d = StSkip;
          end else if (in_base == itoa_pkg::BaseDec) begin
            radix_d = itoa_pkg::RadixDec;
            neg_d   = in_value[31];
            bin_d   = mag;
            sh_d    = '0;
            cnt_d   = 6'd32;
            state_d = StConv;
          end else begin
            state_d = StErr;
          end
        end
      end
      StConv: begin
        sh_d  = {bcd_adj[38:0], bin_q[31]};
        bin_d = {bin_q[30:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          cnt_d   = itoa_pkg::DigitsDec;
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && cnt_q > 6'd1) begin
          sh_d  = sh_next;
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (can_load) begin
          ov_d    = 1'b1;
          oc_d    = itoa_pkg::CharMinus;
          ol_d    = 1'b0;
          ob_d    = 1'b0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (can_load) begin
          ov_d  = 1'b1;
          oc_d  = itoa_pkg::digit_char(top_digit);
          ol_d  = (cnt_q == 6'd1);
          ob_d  = 1'b0;
          sh_d  = sh_next;
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_d = StIdle;
          end
        end
      end
      StErr: begin
        if (can_load) begin
          ov_d    = 1'b1;
          oc_d    = itoa_pkg::CharNul;
          ol_d    = 1'b1;
          ob_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      radix_q <= itoa_pkg::RadixBin;
      neg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bin_q <= bin_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
    ob_q  <= ob_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = oc_q;
  assign m_axis_tlast_o  = ol_q;
  assign m_axis_tuser_o  = ob_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ob_q) |-> ol_q)
    else $error("error item not marked last");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != StIdle))
    else $error("accepted item did not start conversion");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StConv || state_q == StSkip) |-> (cnt_q != 6'd0))
    else $error("digit counter ran out while busy");

  a_sign_dec_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSign) |-> (radix_q == itoa_pkg::RadixDec))
    else $error("minus sign outside base 10");

endmodule

`default_nettype wire
